// ===== src/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Types and codes shared by the periodic task dispatcher modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ptd_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_DEL   = 2'd2;
  localparam logic [1:0] REQ_SCHED = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RANGE    = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_ABSENT   = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  localparam logic [1:0] TM_ONTIME = 2'd0;
  localparam logic [1:0] TM_LATE   = 2'd1;
  localparam logic [1:0] TM_MISSED = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  task_id;
    logic [15:0] task_tag;
    logic [15:0] period;
    logic [15:0] first_start;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        dispatch_valid;
    logic [5:0]  dispatch_id;
    logic [15:0] dispatch_tag;
    logic [1:0]  timing;
    logic [31:0] tick_now;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request
    logic simple;   // execute tick/add/delete
    logic scan;     // scan the slot under the cursor
    logic fin_rd;   // read the dispatch slot
    logic fin;      // finish dispatch and build result
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/ptd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptd_ctrl
// Request sequencer: simple requests in one step, schedule passes by scan.
// ----------------------------------------------------------------------------
`default_nettype none
module ptd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    req_type,
  output logic               in_stall,
  input  wire logic          out_stall,
  output logic               out_valid,
  output ptd_pkg::ctl_t      ctl,
  input  wire ptd_pkg::sts_t sts
);
  import ptd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       sched_r, sched_nxt;
  logic       acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    sched_nxt = sched_r;
    ctl = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          ctl.load  = 1'b1;
          sched_nxt = (req_type == REQ_SCHED);
          state_nxt = (req_type == REQ_SCHED) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.simple = 1'b1;
        state_nxt  = S_OUT;
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_last) state_nxt = S_FRD;
      end
      S_FRD: begin
        ctl.fin_rd = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        ctl.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sched_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sched_r <= sched_nxt;
    end
  end

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_FIN))
    else $error("result without work");
  a_fin_sched: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> sched_r)
    else $error("dispatch outside schedule pass");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> !$past(acc))
    else $error("accept while scanning");
endmodule
`default_nettype wire

// ===== src/ptd_dp.sv =====
// ----------------------------------------------------------------------------
// ptd_dp
// Slot tables, tick counter, scan cursor and dispatch arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none
module ptd_dp #(
  parameter int GROUPS = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ptd_pkg::req_t in_req,
  input  wire ptd_pkg::ctl_t ctl,
  output ptd_pkg::sts_t      sts,
  output ptd_pkg::rsp_t      rsp
);
  import ptd_pkg::*;

  localparam int NS = GROUPS * 32;
  localparam int SW = $clog2(NS);

  req_t         req_r;
  rsp_t         rsp_r, rsp_nxt;
  logic [31:0]  tick_r;
  logic [NS-1:0] en_r, act_r, wr_r;
  logic [15:0]  per_mem [NS];
  logic [31:0]  st_mem  [NS];
  logic [15:0]  tag_mem [NS];

  // scan pipeline: cursor address, then registered read
  logic [SW:0]  cur_r;
  logic         rv_r;
  logic [SW-1:0] ra_r;
  logic [15:0]  per_q;
  logic [31:0]  st_q;
  logic [15:0]  tag_q;

  logic [SW-1:0] low_id;
  logic          any_act;
  logic          in_rng;
  logic [SW-1:0] rid;
  logic [31:0]   per_v, st_v, el;
  logic [15:0]   tag_v;

  assign in_rng = ({24'd0, req_r.task_id} < 32'(NS));
  assign rid    = req_r.task_id[SW-1:0];
  // entries never written read as zero
  assign per_v  = wr_r[ra_r] ? {16'd0, per_q} : 32'd0;
  assign st_v   = wr_r[ra_r] ? st_q : 32'd0;
  assign tag_v  = wr_r[ra_r] ? tag_q : 16'd0;
  assign el     = tick_r - st_v;
  assign sts.scan_last = (cur_r == (SW+1)'(NS));
  assign rsp = rsp_r;

  always_comb begin
    low_id  = '0;
    any_act = |act_r;
    for (int i = NS - 1; i >= 0; i--) begin
      if (act_r[i]) low_id = SW'(i);
    end
  end

  logic [SW-1:0] mrd;
  always_comb begin
    if (ctl.load) mrd = in_req.task_id[SW-1:0];
    else if (ctl.fin_rd) mrd = low_id;
    else if (ctl.simple) mrd = rid;
    else mrd = cur_r[SW-1:0];
  end

  always_comb begin
    rsp_nxt = '0;
    rsp_nxt.tick_now = tick_r;
    if (ctl.simple) begin
      case (req_r.req_type)
        REQ_TICK: rsp_nxt.tick_now = tick_r + 32'd1;
        REQ_ADD: begin
          if (!in_rng) rsp_nxt.status = ST_RANGE;
          else if (en_r[rid]) rsp_nxt.status = ST_EXISTS;
        end
        REQ_DEL: begin
          if (!in_rng) rsp_nxt.status = ST_RANGE;
          else if (!en_r[rid]) rsp_nxt.status = ST_ABSENT;
          else if (tag_v != req_r.task_tag) rsp_nxt.status = ST_MISMATCH;
        end
        default: rsp_nxt.status = ST_OK;
      endcase
    end else if (ctl.fin && any_act) begin
      rsp_nxt.dispatch_valid = 1'b1;
      rsp_nxt.dispatch_id    = 6'(ra_r);
      rsp_nxt.dispatch_tag   = tag_v;
      if (per_v == 32'd0) rsp_nxt.timing = TM_ONTIME;
      else if (el >= per_v) rsp_nxt.timing = TM_MISSED;
      else if (el >= {1'b0, per_v[31:1]}) rsp_nxt.timing = TM_LATE;
    end
  end

  always_ff @(posedge clk) begin
    per_q <= per_mem[mrd];
    st_q  <= st_mem[mrd];
    tag_q <= tag_mem[mrd];
    ra_r  <= mrd;
    if (ctl.load) req_r <= in_req;
    if (ctl.simple && in_rng && req_r.req_type == REQ_ADD && !en_r[rid]) begin
      per_mem[rid] <= req_r.period;
      st_mem[rid]  <= {16'd0, req_r.first_start};
      tag_mem[rid] <= req_r.task_tag;
    end else if (ctl.scan && rv_r && en_r[ra_r] && el >= per_v) begin
      st_mem[ra_r] <= st_v + per_v;
    end else if (ctl.fin && any_act && per_v != 32'd0 && el >= per_v) begin
      st_mem[ra_r] <= st_v + per_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      en_r   <= '0;
      act_r  <= '0;
      wr_r   <= '0;
      cur_r  <= '0;
      rv_r   <= 1'b0;
      rsp_r  <= '0;
    end else begin
      rv_r <= ctl.scan && !sts.scan_last;
      if (ctl.load) cur_r <= '0;
      else if (ctl.scan && !sts.scan_last) cur_r <= cur_r + (SW+1)'(1);
      if (ctl.scan && rv_r && en_r[ra_r] && el >= per_v) act_r[ra_r] <= 1'b1;
      if (ctl.simple || ctl.fin) rsp_r <= rsp_nxt;
      if (ctl.simple) begin
        case (req_r.req_type)
          REQ_TICK: tick_r <= tick_r + 32'd1;
          REQ_ADD: begin
            if (in_rng && !en_r[rid]) begin
              en_r[rid] <= 1'b1;
              wr_r[rid] <= 1'b1;
            end
          end
          REQ_DEL: begin
            if (in_rng && en_r[rid] && tag_v == req_r.task_tag) begin
              en_r[rid]  <= 1'b0;
              act_r[rid] <= 1'b0;
              wr_r[rid]  <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (ctl.fin && any_act) begin
        act_r[ra_r] <= 1'b0;
        if (per_v == 32'd0) en_r[ra_r] <= 1'b0;
      end
    end
  end

  a_act_en: assert property (@(posedge clk) disable iff (!rst_n)
    ((act_r & ~en_r) == '0)) else $error("active slot not enabled");
  a_en_wr: assert property (@(posedge clk) disable iff (!rst_n)
    ((en_r & ~wr_r) == '0)) else $error("enabled slot never written");
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(tick_r) |-> ($past(ctl.simple) && $past(req_r.req_type) == REQ_TICK))
    else $error("tick moved outside tick request");
endmodule
`default_nettype wire

// ===== src/periodic_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Slot-table task scheduler with tick, add, delete and schedule requests.
// ----------------------------------------------------------------------------
// Tick, add and delete requests are executed in a single step from accept to
// result. A schedule pass walks the slot table one slot per cycle through the
// single read port of the slot memories, then reads the chosen slot once
// more. One request is in work at a time; the result waits in the output
// register until taken.
`default_nettype none
module periodic_task_dispatcher #(
  parameter int GROUPS = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ptd_pkg::req_t in_req,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ptd_pkg::rsp_t      out_rsp
);
  import ptd_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ptd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .req_type  (in_req.req_type),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .ctl       (ctl),
    .sts       (sts)
  );

  ptd_dp #(.GROUPS(GROUPS)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .ctl    (ctl),
    .sts    (sts),
    .rsp    (out_rsp)
  );
endmodule
`default_nettype wire

// ===== verif/periodic_task_dispatcher_test.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_test
// Drives tick, add, delete and schedule requests through the valid/stall
// request channel and compares every response field against a behavioral
// model of the slot table, with random request gaps and random output stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module periodic_task_dispatcher_test;
  import ptd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  always #2 clk = ~clk;

  periodic_task_dispatcher dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req(in_req), .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
  );

  // scheduler model
  logic [31:0] m_tick;
  logic [NSLOT-1:0] m_en, m_act;
  logic [15:0] m_period [NSLOT];
  logic [31:0] m_start [NSLOT];
  logic [15:0] m_tag [NSLOT];

  rsp_t pending_rsp [$];
  int mismatches = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  function automatic rsp_t dispatch_model(req_t r);
    rsp_t o;
    int s;
    logic [31:0] el, p;
    o = '0;
    case (r.req_type)
      REQ_TICK: m_tick = m_tick + 32'd1;
      REQ_ADD, REQ_DEL: begin
        if (r.task_id >= NSLOT) begin
          o.status = ST_RANGE;
        end else if (r.req_type == REQ_ADD) begin
          if (m_en[r.task_id]) begin
            o.status = ST_EXISTS;
          end else begin
            m_en[r.task_id] = 1'b1;
            m_tag[r.task_id] = r.task_tag;
            m_period[r.task_id] = r.period;
            m_start[r.task_id] = {16'd0, r.first_start};
          end
        end else if (!m_en[r.task_id]) begin
          o.status = ST_ABSENT;
        end else if (m_tag[r.task_id] != r.task_tag) begin
          o.status = ST_MISMATCH;
        end else begin
          m_en[r.task_id] = 1'b0;
          m_act[r.task_id] = 1'b0;
          m_tag[r.task_id] = '0;
          m_period[r.task_id] = '0;
          m_start[r.task_id] = '0;
        end
      end
      default: begin
        for (int i = 0; i < NSLOT; i++) begin
          if (m_en[i] && (m_tick - m_start[i]) >= {16'd0, m_period[i]}) begin
            m_act[i] = 1'b1;
            m_start[i] = m_start[i] + {16'd0, m_period[i]};
          end
        end
        s = -1;
        for (int i = 0; i < NSLOT; i++) begin
          if (m_act[i] && s < 0) s = i;
        end
        if (s >= 0) begin
          m_act[s] = 1'b0;
          p = {16'd0, m_period[s]};
          if (p == 0) begin
            m_en[s] = 1'b0;
          end else begin
            el = m_tick - m_start[s];
            if (el >= p) begin
              o.timing = TM_MISSED;
              m_start[s] = m_start[s] + p;
            end else if (el >= (p >> 1)) begin
              o.timing = TM_LATE;
            end
          end
          o.dispatch_valid = 1'b1;
          o.dispatch_id = s[5:0];
          o.dispatch_tag = m_tag[s];
        end
      end
    endcase
    o.tick_now = m_tick;
    return o;
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_request(req_t r);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req <= r;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_rsp.push_back(dispatch_model(r));
    @(negedge clk);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    wait (pending_rsp.size() == 0);
    @(negedge clk);
  endtask

  function automatic req_t mk(logic [1:0] t, logic [7:0] id, logic [15:0] tg,
                              logic [15:0] p, logic [15:0] f);
    req_t r;
    r.req_type = t;
    r.task_id = id;
    r.task_tag = tg;
    r.period = p;
    r.first_start = f;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int k;
    r = req_t'({$urandom, $urandom});
    k = $urandom_range(0, 99);
    if (k < 30) r.req_type = REQ_TICK;
    else if (k < 55) r.req_type = REQ_ADD;
    else if (k < 70) r.req_type = REQ_DEL;
    else r.req_type = REQ_SCHED;
    if ($urandom_range(0, 9) != 0)
      r.task_id = 8'($urandom_range(0, 12) + ($urandom_range(0, 1) * 50));
    if ($urandom_range(0, 3) != 0) r.task_tag = 16'($urandom_range(1, 4));
    if ($urandom_range(0, 4) != 0) r.period = 16'($urandom_range(0, 12));
    if ($urandom_range(0, 4) != 0)
      r.first_start = 16'(m_tick[15:0] + $urandom_range(0, 6) - 3);
    return r;
  endfunction

  typedef struct packed {
    req_t r;
    logic known;
    rsp_t e;
  } row_t;

  row_t plan [] = '{
    '{mk(REQ_SCHED, 0, 0, 0, 0), 1'b1, '0},
    '{mk(REQ_TICK, 0, 0, 0, 0), 1'b1, rsp_t'(32'd1)},
    '{mk(REQ_ADD, 64, 1, 1, 1), 1'b1, '{ST_RANGE, 1'b0, 6'd0, 16'd0, TM_ONTIME, 32'd1}},
    '{mk(REQ_DEL, 255, 1, 0, 0), 1'b1, '{ST_RANGE, 1'b0, 6'd0, 16'd0, TM_ONTIME, 32'd1}},
    '{mk(REQ_DEL, 5, 1, 0, 0), 1'b1, '{ST_ABSENT, 1'b0, 6'd0, 16'd0, TM_ONTIME, 32'd1}},
    '{mk(REQ_ADD, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, rsp_t'(32'd1)},
    '{mk(REQ_ADD, 63, 2, 2, 2), 1'b1, '{ST_EXISTS, 1'b0, 6'd0, 16'd0, TM_ONTIME, 32'd1}},
    '{mk(REQ_DEL, 63, 16'hFFFE, 0, 0), 1'b1,
      '{ST_MISMATCH, 1'b0, 6'd0, 16'd0, TM_ONTIME, 32'd1}},
    '{mk(REQ_ADD, 0, 16'hAAAA, 0, 0), 1'b0, '0},
    '{mk(REQ_ADD, 32, 16'h5555, 4, 1), 1'b0, '0},
    '{mk(REQ_ADD, 31, 16'h00FF, 8, 16'h8000), 1'b0, '0},
    '{mk(REQ_SCHED, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_SCHED, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_TICK, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_TICK, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_TICK, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_TICK, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_SCHED, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_TICK, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_TICK, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_TICK, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_SCHED, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_SCHED, 0, 0, 0, 0), 1'b0, '0},
    '{mk(REQ_DEL, 63, 16'hFFFF, 0, 0), 1'b0, '0},
    '{mk(REQ_DEL, 32, 16'h5555, 0, 0), 1'b0, '0}
  };

  always @(posedge clk) begin
    rsp_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", out_rsp);
      end else begin
        e = pending_rsp.pop_front();
        if (out_rsp !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, out_rsp);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
    else if ($urandom_range(0, 2) == 0) out_stall <= 1'b0;
  end

  initial begin
    @(posedge stim_done);
  end

  initial begin
    m_tick = '0;
    m_en = '0;
    m_act = '0;
    for (int i = 0; i < NSLOT; i++) begin
      m_period[i] = '0;
      m_start[i] = '0;
      m_tag[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) begin
      if (plan[i].known) pending_rsp.push_back(plan[i].e);
      send_request(plan[i].r);
      if (plan[i].known) void'(pending_rsp.pop_back());
    end
    drain_requests();
    for (int n = 0; n < 600; n++) begin
      if (n == 150) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (600) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (n == 300) drain_requests();
      send_request(random_request());
    end
    stim_done = 1'b1;
    drain_requests();
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("periodic_task_dispatcher_test: PASS");
    else $display("periodic_task_dispatcher_test: FAIL");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("periodic_task_dispatcher_test: FAIL");
    $finish;
  end

  final begin
  end
endmodule
`default_nettype wire
